// ----- sv/xml_element_content_extractor_defines.svh -----
// Assertion macros shared by the checker of the XML element content extractor.
`ifndef XML_ELEMENT_CONTENT_EXTRACTOR_DEFINES_SVH
`define XML_ELEMENT_CONTENT_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define XEC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define XEC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/xec_pkg.sv -----
// Types, constants and helper functions of the XML element content extractor.
package xec_pkg;

   localparam int MAX_NAME_BYTES = 8;
   localparam int NIDX_W         = $clog2(MAX_NAME_BYTES);
   localparam int NPOS_W         = $clog2(MAX_NAME_BYTES + 1);
   localparam int HOLD_DEPTH     = MAX_NAME_BYTES + 2;
   localparam int HCNT_W         = $clog2(HOLD_DEPTH + 1);
   // held bytes, the current byte and one marker
   localparam int STEP_W         = $clog2(HOLD_DEPTH + 3);

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam int TAG_NAME_W  = 64;
   localparam int TAG_LEN_W   = 4;
   localparam int LIMIT_W     = 16;

   localparam logic [TAG_NAME_W-1:0] TAG_NAME_RESET  = '0;
   localparam logic [TAG_LEN_W-1:0]  TAG_LEN_RESET   = 4'd1;
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = 16'd4096;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [3:0] {
      MODE_OUTSIDE,
      MODE_LT,
      MODE_NAME,
      MODE_SKIP,
      MODE_BANG1,
      MODE_BANG2,
      MODE_COMMENT,
      MODE_CDASH1,
      MODE_CDASH2,
      MODE_CONTENT,
      MODE_CLOSE_LT,
      MODE_CLOSE_NAME
   } parse_mode_type;

   typedef enum logic [1:0] {
      KIND_CONTENT = 2'd0,
      KIND_END     = 2'd1,
      KIND_ERROR   = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      REG_TAG_NAME,
      REG_TAG_LENGTH,
      REG_CONTENT_LIMIT,
      REG_STRIP_WHITESPACE
   } reg_index_type;

   typedef logic [MAX_NAME_BYTES-1:0][7:0] name_bytes_type;

   typedef struct packed {
      logic [TAG_NAME_W-1:0] tag_name;
      logic [TAG_LEN_W-1:0]  tag_length;
      logic [LIMIT_W-1:0]    content_limit;
      logic                  strip_whitespace;
   } cfg_type;

   // One parsed input byte: release held bytes, then maybe the current byte,
   // then maybe an element end or an error marker.
   typedef struct packed {
      logic [HCNT_W-1:0] rel_count;
      logic              cur_valid;
      logic [7:0]        cur_byte;
      logic              end_elem;
      logic              error;
      name_bytes_type    name_bytes;
   } cmd_type;

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      data;
      logic            truncated;
      logic            last_of_run;
   } result_type;

   function automatic logic is_alnum(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR) || (b == CHAR_SPACE);
   endfunction

   function automatic logic [NPOS_W-1:0] eff_length(input logic [TAG_LEN_W-1:0] len);
      logic [NPOS_W-1:0] res;
      if (len > TAG_LEN_W'(MAX_NAME_BYTES)) begin
         res = NPOS_W'(MAX_NAME_BYTES);
      end else begin
         res = NPOS_W'(len);
      end
      return res;
   endfunction

   function automatic logic [7:0] name_byte(input logic [TAG_NAME_W-1:0] name,
                                            input logic [NIDX_W-1:0] k);
      return name[{k, 3'b000} +: 8];
   endfunction

endpackage

// ----- sv/xml_element_content_extractor.sv -----
// Top level of the XML element content extractor: parser, command queue, result generator.
// Each byte's command is registered in the command queue before the generator works its slots;
// a result is registered in the result queue, or held until the byte's next result when more follow.
// Throughput: one byte per cycle while the command queue is not full; the generator works each
// released, current or marker slot of a byte in turn, and stalls while the result queue is full.
// Reset: synchronous, active high; clears parser state, queues, counters and registers.
module xml_element_content_extractor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_end_of_document,
   output logic                           empty,
   input  logic                           pop,
   output logic [1:0]                     rsp_result_kind,
   output logic [7:0]                     rsp_content_byte,
   output logic                           rsp_truncated,
   output logic                           rsp_last_of_run,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [xec_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [xec_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [xec_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   xec_pkg::cfg_type    cfg;
   xec_pkg::cmd_type    cmd_wr, cmd_head;
   xec_pkg::result_type rsp_head;
   logic                cmd_push, cmd_full, cmd_valid, cmd_pop;

   xec_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   xec_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_push  (push),
      .in_byte  (req_in_byte),
      .in_eod   (req_end_of_document),
      .cmd_full (cmd_full),
      .in_full  (full),
      .cmd_push (cmd_push),
      .cmd_out  (cmd_wr)
   );

   xec_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head)
   );

   xec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp       (rsp_head)
   );

   assign rsp_result_kind  = rsp_head.kind;
   assign rsp_content_byte = rsp_head.data;
   assign rsp_truncated    = rsp_head.truncated;
   assign rsp_last_of_run  = rsp_head.last_of_run;

endmodule

// ----- sv/xec_csr.sv -----
// Configuration registers of the extractor behind an APB-style port.
module xec_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [xec_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [xec_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [xec_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output xec_pkg::cfg_type                cfg
);

   logic [xec_pkg::TAG_NAME_W-1:0] tag_name_ff;
   logic [xec_pkg::TAG_LEN_W-1:0]  tag_length_ff;
   logic [xec_pkg::LIMIT_W-1:0]    content_limit_ff;
   logic                           strip_ff;
   logic                           wr_en;
   xec_pkg::reg_index_type         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = xec_pkg::reg_index_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_name_ff      <= xec_pkg::TAG_NAME_RESET;
         tag_length_ff    <= xec_pkg::TAG_LEN_RESET;
         content_limit_ff <= xec_pkg::LIMIT_RESET;
         strip_ff         <= 1'b0;
      end else if (wr_en) begin
         unique case (reg_idx)
            xec_pkg::REG_TAG_NAME:         tag_name_ff <= pwdata[xec_pkg::TAG_NAME_W-1:0];
            xec_pkg::REG_TAG_LENGTH:       tag_length_ff <= pwdata[xec_pkg::TAG_LEN_W-1:0];
            xec_pkg::REG_CONTENT_LIMIT:    content_limit_ff <= pwdata[xec_pkg::LIMIT_W-1:0];
            xec_pkg::REG_STRIP_WHITESPACE: strip_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         xec_pkg::REG_TAG_NAME:
            prdata = tag_name_ff;
         xec_pkg::REG_TAG_LENGTH:
            prdata = {{(xec_pkg::CSR_DATA_W - xec_pkg::TAG_LEN_W){1'b0}}, tag_length_ff};
         xec_pkg::REG_CONTENT_LIMIT:
            prdata = {{(xec_pkg::CSR_DATA_W - xec_pkg::LIMIT_W){1'b0}}, content_limit_ff};
         xec_pkg::REG_STRIP_WHITESPACE:
            prdata = {{(xec_pkg::CSR_DATA_W - 1){1'b0}}, strip_ff};
         default:
            prdata = '0;
      endcase
   end

   assign cfg.tag_name         = tag_name_ff;
   assign cfg.tag_length       = tag_length_ff;
   assign cfg.content_limit    = content_limit_ff;
   assign cfg.strip_whitespace = strip_ff;

endmodule

// ----- sv/xec_front.sv -----
// Markup parser: classifies each document byte and issues release/content/end/error commands.
module xec_front (
   input  logic             clock,
   input  logic             reset,
   input  xec_pkg::cfg_type cfg,
   input  logic             in_push,
   input  logic [7:0]       in_byte,
   input  logic             in_eod,
   input  logic             cmd_full,
   output logic             in_full,
   output logic             cmd_push,
   output xec_pkg::cmd_type cmd_out
);

   xec_pkg::parse_mode_type        mode_ff, mode_in;
   logic [xec_pkg::NPOS_W-1:0]     np_ff, np_in;
   logic                           err_ff, err_in;
   xec_pkg::name_bytes_type        held_ff, held_in;
   logic                           accept;

   assign in_full = cmd_full;
   assign accept  = in_push && !cmd_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= xec_pkg::MODE_OUTSIDE;
         np_ff   <= '0;
         err_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         np_ff   <= np_in;
         err_ff  <= err_in;
      end
   end

   // matched name bytes of a possible closing tag
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   always_comb begin
      logic [xec_pkg::NPOS_W-1:0] len;
      logic                       name_hit;
      xec_pkg::parse_mode_type    mode_step;
      len      = xec_pkg::eff_length(cfg.tag_length);
      name_hit = (np_ff < len) &&
                 (in_byte == xec_pkg::name_byte(cfg.tag_name,
                                                np_ff[xec_pkg::NIDX_W-1:0]));
      mode_in  = mode_ff;
      np_in    = np_ff;
      err_in   = err_ff;
      held_in  = held_ff;
      cmd_out  = '0;
      cmd_out.cur_byte = in_byte;

      if (!err_ff) begin
         unique case (mode_ff)
            xec_pkg::MODE_OUTSIDE: begin
               if (in_byte == xec_pkg::CHAR_LT) mode_in = xec_pkg::MODE_LT;
            end
            xec_pkg::MODE_LT: begin
               if (in_byte == xec_pkg::CHAR_SLASH || in_byte == xec_pkg::CHAR_QMARK) begin
                  mode_in = xec_pkg::MODE_SKIP;
               end else if (in_byte == xec_pkg::CHAR_BANG) begin
                  mode_in = xec_pkg::MODE_BANG1;
               end else if (xec_pkg::is_alnum(in_byte)) begin
                  if (len != '0 && in_byte == xec_pkg::name_byte(cfg.tag_name, '0)) begin
                     np_in   = xec_pkg::NPOS_W'(1);
                     mode_in = xec_pkg::MODE_NAME;
                  end else begin
                     mode_in = xec_pkg::MODE_SKIP;
                  end
               end else begin
                  err_in        = 1'b1;
                  mode_in       = xec_pkg::MODE_OUTSIDE;
                  cmd_out.error = 1'b1;
               end
            end
            xec_pkg::MODE_NAME: begin
               if (in_byte == xec_pkg::CHAR_GT) begin
                  mode_in = (np_ff == len) ? xec_pkg::MODE_CONTENT : xec_pkg::MODE_OUTSIDE;
               end else if (name_hit) begin
                  np_in = np_ff + 1'b1;
               end else begin
                  mode_in = xec_pkg::MODE_SKIP;
               end
            end
            xec_pkg::MODE_SKIP: begin
               if (in_byte == xec_pkg::CHAR_GT) mode_in = xec_pkg::MODE_OUTSIDE;
            end
            xec_pkg::MODE_BANG1: begin
               if (in_byte == xec_pkg::CHAR_DASH) begin
                  mode_in = xec_pkg::MODE_BANG2;
               end else begin
                  err_in        = 1'b1;
                  mode_in       = xec_pkg::MODE_OUTSIDE;
                  cmd_out.error = 1'b1;
               end
            end
            xec_pkg::MODE_BANG2: begin
               if (in_byte == xec_pkg::CHAR_DASH) begin
                  mode_in = xec_pkg::MODE_COMMENT;
               end else begin
                  err_in        = 1'b1;
                  mode_in       = xec_pkg::MODE_OUTSIDE;
                  cmd_out.error = 1'b1;
               end
            end
            xec_pkg::MODE_COMMENT: begin
               if (in_byte == xec_pkg::CHAR_DASH) mode_in = xec_pkg::MODE_CDASH1;
            end
            xec_pkg::MODE_CDASH1: begin
               mode_in = (in_byte == xec_pkg::CHAR_DASH) ? xec_pkg::MODE_CDASH2
                                                         : xec_pkg::MODE_COMMENT;
            end
            xec_pkg::MODE_CDASH2: begin
               if (in_byte == xec_pkg::CHAR_GT) begin
                  mode_in = xec_pkg::MODE_OUTSIDE;
               end else if (in_byte != xec_pkg::CHAR_DASH) begin
                  mode_in = xec_pkg::MODE_COMMENT;
               end
            end
            xec_pkg::MODE_CONTENT: begin
               if (in_byte == xec_pkg::CHAR_LT) begin
                  mode_in = xec_pkg::MODE_CLOSE_LT;
               end else begin
                  cmd_out.cur_valid = 1'b1;
               end
            end
            xec_pkg::MODE_CLOSE_LT: begin
               if (in_byte == xec_pkg::CHAR_SLASH) begin
                  np_in   = '0;
                  mode_in = xec_pkg::MODE_CLOSE_NAME;
               end else begin
                  cmd_out.rel_count = xec_pkg::HCNT_W'(1);
                  if (in_byte == xec_pkg::CHAR_LT) begin
                     mode_in = xec_pkg::MODE_CLOSE_LT;
                  end else begin
                     cmd_out.cur_valid = 1'b1;
                     mode_in           = xec_pkg::MODE_CONTENT;
                  end
               end
            end
            xec_pkg::MODE_CLOSE_NAME: begin
               if (in_byte == xec_pkg::CHAR_GT && np_ff == len) begin
                  cmd_out.end_elem = 1'b1;
                  np_in            = '0;
                  mode_in          = xec_pkg::MODE_OUTSIDE;
               end else if (name_hit) begin
                  held_in[np_ff[xec_pkg::NIDX_W-1:0]] = in_byte;
                  np_in = np_ff + 1'b1;
               end else begin
                  // "</" plus the matched name bytes go out as content
                  cmd_out.rel_count = xec_pkg::HCNT_W'(2) + xec_pkg::HCNT_W'(np_ff);
                  if (in_byte == xec_pkg::CHAR_LT) begin
                     mode_in = xec_pkg::MODE_CLOSE_LT;
                  end else begin
                     cmd_out.cur_valid = 1'b1;
                     mode_in           = xec_pkg::MODE_CONTENT;
                  end
               end
            end
            default: mode_in = xec_pkg::MODE_OUTSIDE;
         endcase
      end

      mode_step = mode_in;
      if (in_eod) begin
         if (!err_in && (mode_step == xec_pkg::MODE_CONTENT ||
                         mode_step == xec_pkg::MODE_CLOSE_LT ||
                         mode_step == xec_pkg::MODE_CLOSE_NAME)) begin
            cmd_out.end_elem = 1'b1;
            // a lone held '<' is always this byte
            if (mode_step == xec_pkg::MODE_CLOSE_LT) cmd_out.cur_valid = 1'b1;
            if (mode_step == xec_pkg::MODE_CLOSE_NAME) begin
               cmd_out.rel_count = xec_pkg::HCNT_W'(2) + xec_pkg::HCNT_W'(np_in);
            end
         end
         mode_in = xec_pkg::MODE_OUTSIDE;
         np_in   = '0;
         err_in  = 1'b0;
      end

      cmd_out.name_bytes = held_in;
      cmd_push = accept && (cmd_out.rel_count != '0 || cmd_out.cur_valid ||
                            cmd_out.end_elem || cmd_out.error);
   end

endmodule

// ----- sv/xec_cmd_fifo.sv -----
// Short command queue between the parser and the result generator.
module xec_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xec_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output xec_pkg::cmd_type head
);

   xec_pkg::cmd_type              mem_ff [xec_pkg::CMD_DEPTH];
   logic [xec_pkg::CMD_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [xec_pkg::CMD_CNT_W-1:0] cnt_ff;
   logic                          do_push, do_pop;

   assign full    = (cnt_ff == xec_pkg::CMD_CNT_W'(xec_pkg::CMD_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         cnt_ff <= cnt_ff + xec_pkg::CMD_CNT_W'(do_push) - xec_pkg::CMD_CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- sv/xec_back.sv -----
// Result generator: walks each command, applies strip and limit, queues result items.
module xec_back (
   input  logic               clock,
   input  logic               reset,
   input  xec_pkg::cfg_type   cfg,
   input  logic               cmd_valid,
   input  xec_pkg::cmd_type   cmd,
   output logic               cmd_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output xec_pkg::result_type rsp
);

   logic [xec_pkg::STEP_W-1:0]     sidx_ff, sidx_in;
   logic [xec_pkg::LIMIT_W-1:0]    count_ff, count_in;
   logic                           ovf_ff, ovf_in;
   // one result held back until it is known whether it ends its run
   logic                           stage_valid_ff, stage_valid_in;
   logic                           stage_done_ff, stage_done_in;
   xec_pkg::result_type            stage_ff, stage_in;

   xec_pkg::result_type            out_mem_ff [xec_pkg::RSP_DEPTH];
   logic [xec_pkg::RSP_PTR_W-1:0]  out_wr_ff, out_rd_ff;
   logic [xec_pkg::RSP_CNT_W-1:0]  out_cnt_ff;
   logic                           out_push, out_pop, room;
   xec_pkg::result_type            out_data;

   assign room      = (out_cnt_ff != xec_pkg::RSP_CNT_W'(xec_pkg::RSP_DEPTH));
   assign rsp_empty = (out_cnt_ff == '0);
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp       = out_mem_ff[out_rd_ff];

   always_comb begin
      logic [xec_pkg::STEP_W-1:0] total;
      logic [xec_pkg::STEP_W-1:0] hidx;
      logic                       is_final, in_held, in_cur, cand, white, below, emit;
      logic                       flush, step;
      logic [7:0]                 cand_byte;
      xec_pkg::result_type        new_res;

      total    = xec_pkg::STEP_W'(cmd.rel_count) + xec_pkg::STEP_W'(cmd.cur_valid) +
                 xec_pkg::STEP_W'(cmd.end_elem | cmd.error);
      is_final = (sidx_ff == total - 1'b1);
      in_held  = (sidx_ff < xec_pkg::STEP_W'(cmd.rel_count));
      in_cur   = !in_held && cmd.cur_valid && (sidx_ff == xec_pkg::STEP_W'(cmd.rel_count));
      cand     = in_held || in_cur;
      hidx     = sidx_ff - xec_pkg::STEP_W'(2);

      if (!in_held) begin
         cand_byte = cmd.cur_byte;
      end else if (sidx_ff == '0) begin
         cand_byte = xec_pkg::CHAR_LT;
      end else if (sidx_ff == xec_pkg::STEP_W'(1)) begin
         cand_byte = xec_pkg::CHAR_SLASH;
      end else begin
         cand_byte = cmd.name_bytes[hidx[xec_pkg::NIDX_W-1:0]];
      end

      white = cfg.strip_whitespace && xec_pkg::is_space(cand_byte);
      below = (count_ff < cfg.content_limit);
      emit  = cand ? (!white && below) : 1'b1;

      new_res.kind        = cand ? xec_pkg::KIND_CONTENT
                                 : (cmd.error ? xec_pkg::KIND_ERROR : xec_pkg::KIND_END);
      new_res.data        = cand ? cand_byte : 8'd0;
      new_res.truncated   = !cand && !cmd.error && ovf_ff;
      new_res.last_of_run = 1'b0;

      flush = stage_valid_ff && stage_done_ff;
      step  = cmd_valid && room && !flush;

      sidx_in        = sidx_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      stage_valid_in = stage_valid_ff;
      stage_done_in  = stage_done_ff;
      stage_in       = stage_ff;
      out_push       = 1'b0;
      out_data       = stage_ff;
      cmd_pop        = 1'b0;

      if (flush) begin
         if (room) begin
            out_push             = 1'b1;
            out_data.last_of_run = 1'b1;
            stage_valid_in       = 1'b0;
            stage_done_in        = 1'b0;
         end
      end else if (step) begin
         if (emit) begin
            if (stage_valid_ff) begin
               out_push       = 1'b1;
               stage_in       = new_res;
               stage_valid_in = 1'b1;
               stage_done_in  = is_final;
            end else if (is_final) begin
               out_push             = 1'b1;
               out_data             = new_res;
               out_data.last_of_run = 1'b1;
            end else begin
               stage_in       = new_res;
               stage_valid_in = 1'b1;
               stage_done_in  = 1'b0;
            end
         end else if (is_final && stage_valid_ff) begin
            out_push             = 1'b1;
            out_data.last_of_run = 1'b1;
            stage_valid_in       = 1'b0;
            stage_done_in        = 1'b0;
         end

         if (cand && !white) begin
            if (below) begin
               count_in = count_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
         if (!cand && !cmd.error) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end

         cmd_pop = is_final;
         sidx_in = is_final ? '0 : sidx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sidx_ff        <= '0;
         count_ff       <= '0;
         ovf_ff         <= 1'b0;
         stage_valid_ff <= 1'b0;
         stage_done_ff  <= 1'b0;
         out_wr_ff      <= '0;
         out_rd_ff      <= '0;
         out_cnt_ff     <= '0;
      end else begin
         sidx_ff        <= sidx_in;
         count_ff       <= count_in;
         ovf_ff         <= ovf_in;
         stage_valid_ff <= stage_valid_in;
         stage_done_ff  <= stage_done_in;
         if (out_push) out_wr_ff <= out_wr_ff + 1'b1;
         if (out_pop)  out_rd_ff <= out_rd_ff + 1'b1;
         out_cnt_ff <= out_cnt_ff + xec_pkg::RSP_CNT_W'(out_push) -
                       xec_pkg::RSP_CNT_W'(out_pop);
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (out_push) out_mem_ff[out_wr_ff] <= out_data;
   end

endmodule

// ----- sv/xec_checker.sv -----
// Port-level assertions on the result channel of the extractor, bound to the top level.
`include "xml_element_content_extractor_defines.svh"

module xec_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic [1:0] rsp_result_kind,
   input logic [7:0] rsp_content_byte,
   input logic       rsp_truncated,
   input logic       rsp_last_of_run
);

   logic        kind_known;
   logic        is_marker;
   logic        is_end;
   logic [11:0] rsp_word;

   assign kind_known = (rsp_result_kind <= xec_pkg::KIND_ERROR);
   assign is_marker  = (rsp_result_kind != xec_pkg::KIND_CONTENT);
   assign is_end     = (rsp_result_kind == xec_pkg::KIND_END);
   assign rsp_word   = {rsp_result_kind, rsp_content_byte, rsp_truncated, rsp_last_of_run};

   `XEC_ASSERT_IMPLY(a_kind_code, !empty, kind_known, "undefined result kind")
   `XEC_ASSERT_IMPLY(a_mark_byte, !empty && is_marker, rsp_content_byte == 8'd0, "marker byte set")
   `XEC_ASSERT_IMPLY(a_trunc_end, !empty && !is_end, !rsp_truncated, "truncated off an end")
   `XEC_ASSERT_IMPLY(a_mark_last, !empty && is_marker, rsp_last_of_run, "marker not last of run")
   `XEC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(rsp_word), "stalled result changed")

endmodule

bind xml_element_content_extractor xec_checker u_xec_checker (
   .clock            (clock),
   .reset            (reset),
   .empty            (empty),
   .pop              (pop),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_content_byte (rsp_content_byte),
   .rsp_truncated    (rsp_truncated),
   .rsp_last_of_run  (rsp_last_of_run)
);
